FILE: rtl/core/ewr_pkg.sv
// ----------------------------------------------------------------------------
// Element width repacker package
// Shared types, register map and width decoding for the repacker.
// ----------------------------------------------------------------------------
package ewr_pkg;

    // Width of the element counter and the kept part of the length register
    localparam int LENGTH_BITS = 16;

    // Register map: index of each register (byte address is 4 * index)
    localparam logic [1:0] REG_SOURCE_WIDTH = 2'd0;
    localparam logic [1:0] REG_TARGET_WIDTH = 2'd1;
    localparam logic [1:0] REG_SOURCE_LENGTH = 2'd2;

    // Width codes as written to the width registers
    localparam logic [1:0] CODE_BIT = 2'd0;
    localparam logic [1:0] CODE_NIBBLE = 2'd1;

    typedef enum logic [1:0]
    {
        BEAT_BIT,
        BEAT_NIBBLE,
        BEAT_BYTE
    } beat_width_t;

    typedef struct packed
    {
        logic [1:0] source_width_code;
        logic [1:0] target_width_code;
        logic [LENGTH_BITS-1:0] source_length;
        logic restart;
    } cfg_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic [3:0] count;
        beat_width_t width;
        logic string_last;
    } burst_t;

    // Decode a width code; code three means a byte
    function automatic beat_width_t width_of_code(input logic [1:0] code);
        beat_width_t w;
        begin
            case (code)
                CODE_BIT: w = BEAT_BIT;
                CODE_NIBBLE: w = BEAT_NIBBLE;
                default: w = BEAT_BYTE;
            endcase
            return w;
        end
    endfunction

    function automatic logic [7:0] mask_of_width(input beat_width_t w);
        logic [7:0] m;
        begin
            case (w)
                BEAT_BIT: m = 8'h01;
                BEAT_NIBBLE: m = 8'h0F;
                default: m = 8'hFF;
            endcase
            return m;
        end
    endfunction

endpackage

FILE: rtl/core/ewr_regs.sv
// ----------------------------------------------------------------------------
// Element width repacker registers
// APB register file for the width codes and the string length.
// ----------------------------------------------------------------------------
module ewr_regs
    import ewr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [1:0] source_code_reg;
    logic [1:0] target_code_reg;
    logic [LENGTH_BITS-1:0] length_reg;
    logic write_en;
    logic restart_hit;

    assign pready = 1'b1;
    assign write_en = psel && penable && pwrite;

    // Restart the string on the same edge that writes a known register
    assign restart_hit = write_en && (paddr[3:2] == REG_SOURCE_WIDTH
                                      || paddr[3:2] == REG_TARGET_WIDTH
                                      || paddr[3:2] == REG_SOURCE_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_code_reg <= 2'd2;
            target_code_reg <= 2'd2;
            length_reg <= '0;
        end
        else
        begin
            if (write_en)
            begin
                unique case (paddr[3:2])
                    REG_SOURCE_WIDTH:
                    begin
                        source_code_reg <= pwdata[1:0];
                    end
                    REG_TARGET_WIDTH:
                    begin
                        target_code_reg <= pwdata[1:0];
                    end
                    REG_SOURCE_LENGTH:
                    begin
                        length_reg <= LENGTH_BITS'(pwdata[15:0]);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_SOURCE_WIDTH: prdata = {30'd0, source_code_reg};
            REG_TARGET_WIDTH: prdata = {30'd0, target_code_reg};
            REG_SOURCE_LENGTH: prdata = 32'(length_reg);
            default: prdata = 32'd0;
        endcase
    end

    assign cfg.source_width_code = source_code_reg;
    assign cfg.target_width_code = target_code_reg;
    assign cfg.source_length = length_reg;
    assign cfg.restart = restart_hit;

endmodule

FILE: rtl/core/ewr_front.sv
// ----------------------------------------------------------------------------
// Element width repacker front end
// String state and per-element burst calculation.
// ----------------------------------------------------------------------------
module ewr_front
    import ewr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       accept,
    input  logic [7:0] in_element,
    output logic       burst_valid,
    output burst_t     burst
);

    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [LENGTH_BITS-1:0] seen_reg;
    logic [LENGTH_BITS-1:0] seen_next;
    beat_width_t sw;
    beat_width_t tw;
    logic [7:0] elem;
    logic [7:0] tmask;
    logic [2:0] ratio_mask;
    logic [2:0] rem;
    logic last_elem;
    logic group_done;
    logic [7:0] acc_shifted;

    assign sw = width_of_code(cfg.source_width_code);
    assign tw = width_of_code(cfg.target_width_code);
    assign elem = in_element & mask_of_width(sw);
    assign tmask = mask_of_width(tw);
    assign seen_next = seen_reg + LENGTH_BITS'(1);
    assign last_elem = (seen_next == cfg.source_length);

    always_comb
    begin
        // group size minus one when packing
        if (sw == BEAT_BIT && tw == BEAT_NIBBLE)
            ratio_mask = 3'd3;
        else if (sw == BEAT_BIT)
            ratio_mask = 3'd7;
        else
            ratio_mask = 3'd1;
        rem = cfg.source_length[2:0] & ratio_mask;
        group_done = (((seen_next[2:0] - rem) & ratio_mask) == 3'd0);
        if (sw == BEAT_BIT)
            acc_shifted = {acc_reg[6:0], elem[0]};
        else
            acc_shifted = {acc_reg[3:0], elem[3:0]};
        acc_shifted = acc_shifted & tmask;
    end

    always_comb
    begin
        acc_next = acc_reg;
        burst_valid = 1'b1;
        burst.data = elem;
        burst.count = 4'd1;
        burst.width = BEAT_BYTE;
        burst.string_last = last_elem;
        if (sw == tw)
        begin
            burst.data = elem & tmask;
        end
        else if (sw > tw)
        begin
            // left-align so that the first beat sits in the top bits
            burst.data = (sw == BEAT_NIBBLE) ? {elem[3:0], 4'd0} : elem;
            burst.width = tw;
            if (sw == BEAT_BYTE && tw == BEAT_NIBBLE)
                burst.count = 4'd2;
            else if (sw == BEAT_BYTE)
                burst.count = 4'd8;
            else
                burst.count = 4'd4;
        end
        else
        begin
            burst.data = acc_shifted;
            burst_valid = group_done;
            acc_next = group_done ? 8'd0 : acc_shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'd0;
            seen_reg <= '0;
        end
        else if (cfg.restart)
        begin
            acc_reg <= 8'd0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= last_elem ? 8'd0 : acc_next;
            seen_reg <= last_elem ? '0 : seen_next;
        end
    end

endmodule

FILE: rtl/core/ewr_emit.sv
// ----------------------------------------------------------------------------
// Element width repacker emitter
// Holds one burst and sends it out one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module ewr_emit
    import ewr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  burst_t     burst,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    logic busy_reg;
    logic [3:0] count_reg;
    logic [7:0] data_reg;
    beat_width_t width_reg;
    logic string_last_reg;
    logic beat_done;
    logic final_beat;

    assign m_tvalid = busy_reg;
    assign final_beat = (count_reg == 4'd1);
    assign beat_done = busy_reg && m_tready;
    assign free = !busy_reg || (beat_done && final_beat);
    assign m_tlast = final_beat;
    assign m_tuser = final_beat && string_last_reg;

    always_comb
    begin
        case (width_reg)
            BEAT_BIT: m_tdata = {7'd0, data_reg[7]};
            BEAT_NIBBLE: m_tdata = {4'd0, data_reg[7:4]};
            default: m_tdata = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            count_reg <= 4'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            count_reg <= burst.count;
        end
        else if (beat_done)
        begin
            busy_reg <= !final_beat;
            count_reg <= count_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= burst.data;
            width_reg <= burst.width;
            string_last_reg <= burst.string_last;
        end
        else if (beat_done)
        begin
            case (width_reg)
                BEAT_BIT: data_reg <= {data_reg[6:0], 1'b0};
                BEAT_NIBBLE: data_reg <= {data_reg[3:0], 4'd0};
                default: data_reg <= data_reg;
            endcase
        end
    end

endmodule

FILE: rtl/core/element_width_repacker_top.sv
// ----------------------------------------------------------------------------
// Element width repacker
// Repacks a string of 1, 4 or 8 bit elements to another of those widths.
// ----------------------------------------------------------------------------
// Output: a loaded element shows its first result beat in the cycle after it is taken.
// Throughput: one input beat per cycle when it causes at most one result and the
//   output takes every beat; an unpacking input holds the emitter for its 2, 4 or
//   8 result beats, sent one per cycle while m_tready is high.
// Reset: asynchronous, active low; both widths reset to a byte, length to zero,
//   the string state and the output beat are cleared.
module element_width_repacker_top
    import ewr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: tdata[7:0] = in_element
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // master stream: tdata[7:0] = out_element, tlast = run_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // tuser[0] = string_end
    output logic        m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    burst_t burst;
    logic burst_valid;
    logic emit_free;
    logic accept;

    // Take a new element whenever the emitter is empty or sends its final
    // beat in this cycle; a packing element that closes no group still
    // advances the string state without loading the emitter.
    assign s_tready = emit_free;
    assign accept = s_tvalid && s_tready;

    ewr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Per-element work: mask, count, pack or align, all done combinationally
    ewr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .in_element  (s_tdata),
        .burst_valid (burst_valid),
        .burst       (burst)
    );

    // Result register: holds the burst and walks through its beats
    ewr_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && burst_valid),
        .burst    (burst),
        .free     (emit_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The end of a string always falls on the final beat of its element
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("string end flagged on a beat that is not an element's last");

    // Ready while a beat waits only when that final beat leaves this cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready && m_tvalid |-> m_tready && m_tlast)
        else $error("input taken while a burst is still pending");

    // A beat that was not taken stays on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("pending result beat changed before it was taken");

endmodule

FILE: tb/tb_element_width_repacker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Element width repacker testbench
// Runs the repacker through directed and random pairs of source and target widths,
// including code three. Each setting uses a string length that is short, zero,
// random, or the largest allowed. A local predictor tracks string position and the packing
// group and works out every result beat. A monitor checks each result beat in
// order against that prediction, while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_element_width_repacker_top;
    import ewr_pkg::*;

    // Width code three is decoded as a byte, the same as code two
    localparam logic [1:0] CODE_BYTE = 2'd2;
    localparam logic [1:0] CODE_BYTE_ALT = 2'd3;

    localparam int RANDOM_ELEMENTS = 280;
    // Margin for the longest unpack (eight beats) and the emitter register before its first beat
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        logic [7:0] element;
        logic       run_last;
        logic       string_end;
    } result_t;

    typedef enum int
    {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] in_element
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;             // [7:0] out_element
    logic        m_tlast;
    logic        m_tuser;             // [0] string_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    element_width_repacker_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor copy of the registers and the string state
    logic [1:0]  src_code = CODE_BYTE;
    logic [1:0]  tgt_code = CODE_BYTE;
    logic [15:0] str_len = 16'd0;
    logic [7:0]  pack_acc = 8'd0;
    logic [15:0] taken_in_string = 16'd0;

    result_t     expected_beats[$];
    logic [7:0]  elements_pending[$];
    int          items_left = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    // Driver pacing
    int          burst_left = 0;
    int          gap_left = 0;
    logic        next_valid;
    logic [7:0]  next_data;

    // Receiver stall pattern
    ready_mode_t ready_mode = READY_ALWAYS;
    int          mode_left = 0;
    logic        next_ready;

    // Bit pattern for the directed packing string
    logic n_bits_pattern[10] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                 1'b1, 1'b1};

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Number of bits in an element for a width code; code three is a byte
    function automatic int unsigned bits_of(input logic [1:0] code);
        case (code)
            CODE_BIT: return 1;
            CODE_NIBBLE: return 4;
            default: return 8;
        endcase
    endfunction

    // Work out the result beats caused by one accepted element and queue them
    task automatic repack_element(input logic [7:0] raw);
        int unsigned sw;
        int unsigned tw;
        int unsigned tmask;
        int unsigned elem;
        int unsigned count;
        int unsigned ratio;
        logic [15:0] seen_next;
        logic [15:0] rem;
        logic [15:0] offset;
        logic        closes;
        result_t     beat;
        begin
            sw = bits_of(src_code);
            tw = bits_of(tgt_code);
            tmask = (1 << tw) - 1;
            elem = raw & ((1 << sw) - 1);
            seen_next = taken_in_string + 16'd1;
            closes = (seen_next == str_len);
            if (sw == tw)
            begin
                beat.element = 8'(elem & tmask);
                beat.run_last = 1'b1;
                beat.string_end = closes;
                expected_beats.push_back(beat);
            end
            else if (sw > tw)
            begin
                // Unpack: most significant piece first
                count = sw / tw;
                for (int k = 0; k < count; k++)
                begin
                    beat.element = 8'((elem >> ((count - 1 - k) * tw)) & tmask);
                    beat.run_last = (k == count - 1);
                    beat.string_end = (k == count - 1) && closes;
                    expected_beats.push_back(beat);
                end
            end
            else
            begin
                // Pack: the leading remainder forms a short first group
                ratio = tw / sw;
                rem = 16'(str_len & (ratio - 1));
                offset = seen_next - rem;
                pack_acc = 8'(((pack_acc << sw) | elem) & tmask);
                if ((offset & (ratio - 1)) == 0)
                begin
                    beat.element = pack_acc;
                    beat.run_last = 1'b1;
                    beat.string_end = closes;
                    expected_beats.push_back(beat);
                    pack_acc = 8'd0;
                end
            end
            if (closes)
            begin
                pack_acc = 8'd0;
                taken_in_string = 16'd0;
            end
            else
            begin
                taken_in_string = seen_next;
            end
        end
    endtask

    // Register write: setup cycle, then access cycle; any write restarts the string
    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        begin
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {index, 2'b00};
            pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            case (index)
                REG_SOURCE_WIDTH: src_code = value[1:0];
                REG_TARGET_WIDTH: tgt_code = value[1:0];
                REG_SOURCE_LENGTH: str_len = value[15:0];
                default: ;
            endcase
            pack_acc = 8'd0;
            taken_in_string = 16'd0;
        end
    endtask

    // Hold until every element is taken and every result beat has arrived,
    // then allow for a packing element still being absorbed
    task automatic wait_drained();
        begin
            while (items_left != 0 || expected_beats.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic set_mode(input logic [1:0] src, input logic [1:0] tgt,
                            input logic [15:0] len);
        logic [31:0] junk;
        begin
            wait_drained();
            // Now and then set unused upper bits; the block must drop them
            junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
            apb_write(REG_SOURCE_WIDTH, {junk[31:2], src});
            apb_write(REG_TARGET_WIDTH, {junk[29:0], tgt});
            apb_write(REG_SOURCE_LENGTH, {junk[15:0], len});
        end
    endtask

    task automatic queue_element(input logic [7:0] value);
        begin
            elements_pending.push_back(value);
            items_left++;
        end
    endtask

    // Stimulus: directed corners first, then random phases
    initial
    begin
        int          sent;
        int          n;
        logic [1:0]  src;
        logic [1:0]  tgt;
        logic [15:0] len;
        sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset setting: byte to byte, zero length so the string never closes
        queue_element(8'h00);
        queue_element(8'hFF);
        queue_element(8'hA5);

        // Byte to bits over a two element string, then a new string starts
        set_mode(CODE_BYTE, CODE_BIT, 16'd2);
        queue_element(8'hFF);
        queue_element(8'h00);
        queue_element(8'h81);

        // Bits to byte, length ten: a short leading group of two bits first.
        // Upper bits carry noise that the block must ignore.
        set_mode(CODE_BIT, CODE_BYTE_ALT, 16'd10);
        foreach (n_bits_pattern[i])
            queue_element({7'($urandom), n_bits_pattern[i]});

        // Nibbles to byte, length three: a lone leading nibble, then a pair
        set_mode(CODE_NIBBLE, CODE_BYTE, 16'd3);
        queue_element(8'hFF);
        queue_element(8'h0A);
        queue_element(8'hF5);

        // Byte to nibbles, length one: every element closes its string
        set_mode(CODE_BYTE_ALT, CODE_NIBBLE, 16'd1);
        queue_element(8'hC3);
        queue_element(8'h3C);

        // Random phases: mostly whole strings with random content
        while (sent < RANDOM_ELEMENTS)
        begin
            src = 2'($urandom_range(0, 3));
            tgt = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: len = 16'd0;
                1: len = 16'hFFFF;
                2: len = 16'($urandom);
                default: len = 16'($urandom_range(1, 24));
            endcase
            if (len != 0 && len <= 24)
            begin
                n = len * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(0, len);
            end
            else
            begin
                n = $urandom_range(4, 24);
            end
            set_mode(src, tgt, len);
            repeat (n) queue_element(8'($urandom));
            sent += n;
        end

        wait_drained();
        if (fail_count == 0)
            $display("PASS element_width_repacker_top");
        else
            $display("FAIL element_width_repacker_top");
        $finish;
    end

    // Driver: present queued elements in bursts with random gaps; predict on
    // each accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'h00;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            next_valid = s_tvalid;
            next_data = s_tdata;
            if (s_tvalid && s_tready)
            begin
                repack_element(s_tdata);
                items_left--;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                // Idle data carries noise so nothing leans on it
                next_data = 8'($urandom);
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (elements_pending.size() != 0)
                begin
                    next_data = elements_pending.pop_front();
                    next_valid = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= next_valid;
            s_tdata <= next_data;
        end
    end

    // Receiver: switch to a random stall pattern whenever the current one runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mode_left = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            else
            begin
                mode_left--;
            end
            case (ready_mode)
                READY_ALWAYS: next_ready = 1'b1;
                READY_HALF: next_ready = 1'($urandom_range(0, 1));
                READY_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
                default: next_ready = (cycle_count % 3 != 0);
            endcase
            m_tready <= next_ready;
        end
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result beat: out_element %0h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (m_tdata !== want.element)
                begin
                    $error("out_element: expected %0h, got %0h", want.element, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.string_end)
                begin
                    $error("string_end: expected %0b, got %0b", want.string_end, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL element_width_repacker_top");
            $finish;
        end
    end

endmodule
